>>> hw/rtl/qmf_pkg.sv
// qmf_pkg: shared types and constants for the two-band qmf analysis unit
// word layouts for the request and response channels, sequencer states
// no dependencies
package qmf_pkg;

   localparam int TAPS_DEFAULT = 32;
   localparam int COEF_SLOTS   = 32;
   localparam int SMP_W        = 16;
   localparam int PROD_W       = 2 * SMP_W;
   localparam int ACC_W        = 38;
   localparam int FRAC_BITS    = 15;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic                    operation;
      logic [4:0]              coef_index;
      logic signed [SMP_W-1:0] value;
      logic                    frame_start;
   } qmf_req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] low_band;
      logic signed [SMP_W-1:0] high_band;
      logic                    saturated;
   } qmf_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } qmf_state_type;

endpackage

>>> hw/rtl/qmf_ram.sv
// qmf_ram: generic single-write, single-read ram with registered read data
// no dependencies
module qmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/qmf_two_band_analysis_unit.sv
// qmf_two_band_analysis_unit: two-band qmf analysis filter bank, one shared mac
// load words and off-phase sample words: one per cycle while idle, no result
// on-phase sample words: mac over min(TAPS,32) taps, then drain; result then held in an
// output register while the next word is taken; the mac loop over taps and output back-pressure set the rate
// reset clears taps and delay line logically through valid bits and a fill count
// depends on qmf_pkg and qmf_ram
module qmf_two_band_analysis_unit
   import qmf_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  qmf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output qmf_rsp_type rsp_data
);

   localparam int   DEPTH    = (TAPS < COEF_SLOTS) ? TAPS : COEF_SLOTS;
   localparam int   KW       = $clog2(DEPTH);
   localparam int   FW       = KW + 1;
   localparam int   RW       = ACC_W - FRAC_BITS;
   localparam logic HALF_ODD = ((TAPS / 2) % 2) != 0;

   typedef struct packed {
      logic [SMP_W-1:0] value;
      logic             clip;
   } rnd_type;

   qmf_state_type state_ff, state_in;

   logic [KW-1:0]  k_ff, rp_ff, wp_ff, wp_nxt;
   logic [FW-1:0]  fill_ff;
   logic           phase_ff, phase_n, emit;
   logic [DEPTH-1:0] coef_vld_ff;

   logic           s1_vld_ff, s1_use_ff, s1_odd_ff;
   logic           s2_vld_ff, s2_odd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_lo_ff, acc_hi_ff;

   logic           rsp_valid_ff;
   qmf_rsp_type    rsp_ff;

   logic           accept, smp_acc, ld_acc, issue, load_out, coef_wr;
   logic [SMP_W-1:0] coef_rd, dly_rd;
   rnd_type        lo_r, hi_r;

   function automatic rnd_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] biased;
      logic signed [RW-1:0]    r;
      rnd_type                 res;
      biased = acc + ACC_W'(1 << (FRAC_BITS - 1));
      r      = biased[ACC_W-1:FRAC_BITS];
      if (r > RW'(32767)) begin
         res.value = 16'h7fff;
         res.clip  = 1'b1;
      end else if (r < -RW'(32768)) begin
         res.value = 16'h8000;
         res.clip  = 1'b1;
      end else begin
         res.value = r[SMP_W-1:0];
         res.clip  = 1'b0;
      end
      return res;
   endfunction

   assign accept  = req_valid && req_ready;
   assign smp_acc = accept && (req_data.operation == OP_SAMPLE);
   assign ld_acc  = accept && (req_data.operation == OP_LOAD);
   assign coef_wr = ld_acc && ({1'b0, req_data.coef_index} < 6'(DEPTH));
   assign wp_nxt  = (wp_ff == KW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign phase_n = req_data.frame_start ? 1'b0 : phase_ff;
   assign emit    = (phase_n ^ HALF_ODD) == 1'b0;

   qmf_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (req_data.coef_index[KW-1:0]),
      .wr_data (req_data.value),
      .rd_addr (k_ff),
      .rd_data (coef_rd)
   );

   qmf_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_delay_ram (
      .clock   (clock),
      .wr_en   (smp_acc),
      .wr_addr (wp_nxt),
      .wr_data (req_data.value),
      .rd_addr (rp_ff),
      .rd_data (dly_rd)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_data.operation == OP_SAMPLE) && emit) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            issue = 1'b1;
            if (k_ff == KW'(DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // write pointer, fill count, phase, tap valid bits and stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= '0;
         phase_ff    <= 1'b0;
         coef_vld_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         if (coef_wr) begin
            coef_vld_ff[req_data.coef_index[KW-1:0]] <= 1'b1;
         end
         if (smp_acc) begin
            wp_ff    <= wp_nxt;
            phase_ff <= ~phase_n;
            if (req_data.frame_start) begin
               fill_ff <= FW'(1);
            end else if (fill_ff != FW'(DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // mac datapath: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (smp_acc) begin
         k_ff  <= '0;
         rp_ff <= wp_nxt;
      end else if (issue) begin
         k_ff  <= k_ff + 1'b1;
         rp_ff <= (rp_ff == '0) ? KW'(DEPTH - 1) : rp_ff - 1'b1;
      end
      s1_use_ff <= coef_vld_ff[k_ff] && ({1'b0, k_ff} < fill_ff);
      s1_odd_ff <= k_ff[0];
      prod_ff   <= s1_use_ff ? $signed(coef_rd) * $signed(dly_rd) : PROD_W'(0);
      s2_odd_ff <= s1_odd_ff;
      if (smp_acc) begin
         acc_lo_ff <= '0;
         acc_hi_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_lo_ff <= acc_lo_ff + ACC_W'(prod_ff);
         acc_hi_ff <= s2_odd_ff ? acc_hi_ff + ACC_W'(prod_ff)
                                : acc_hi_ff - ACC_W'(prod_ff);
      end
   end

   // rounding, saturation and output register
   always_comb begin
      lo_r = round_sat(acc_lo_ff);
      hi_r = round_sat(acc_hi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.low_band  <= lo_r.value;
         rsp_ff.high_band <= hi_r.value;
         rsp_ff.saturated <= lo_r.clip | hi_r.clip;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> verif/tb_qmf_two_band_analysis_unit.sv
// tb_qmf_two_band_analysis_unit: self-checking bench for the two-band qmf analysis unit
// drives tap loads and sample words, predicts both decimated bands and checks every result
// depends on qmf_pkg and qmf_two_band_analysis_unit
`timescale 1ns / 100ps

module tb_qmf_two_band_analysis_unit;
   import qmf_pkg::*;

   localparam int NTAPS      = TAPS_DEFAULT;
   localparam int STALL_LIMIT = 3000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   qmf_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   qmf_rsp_type rsp_data;

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int stall_cycles  = 0;

   logic signed [15:0] tap_bank [NTAPS];
   logic signed [15:0] sample_line [NTAPS];
   logic [15:0]        frame_count;
   qmf_rsp_type        pending_bands [$];

   qmf_two_band_analysis_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic signed [15:0] round_q15(input longint acc, output logic clipped);
      longint             r;
      logic signed [15:0] res;
      r = (acc + 64'sd16384) >>> 15;
      clipped = 1'b0;
      res = r[15:0];
      if (r > 32767) begin
         clipped = 1'b1;
         res = 16'sh7FFF;
      end else if (r < -32768) begin
         clipped = 1'b1;
         res = 16'sh8000;
      end
      return res;
   endfunction

   task automatic advance_filter(input qmf_req_type w);
      longint      acc_lo;
      longint      acc_hi;
      longint      prod;
      logic [15:0] n;
      logic        clip_lo;
      logic        clip_hi;
      qmf_rsp_type band_pair;
      if (w.operation == OP_LOAD) begin
         if (int'(w.coef_index) < NTAPS) tap_bank[w.coef_index] = w.value;
      end else begin
         if (w.frame_start) begin
            foreach (sample_line[k]) sample_line[k] = '0;
            frame_count = '0;
         end
         for (int k = NTAPS - 1; k > 0; k--) sample_line[k] = sample_line[k-1];
         sample_line[0] = w.value;
         n = frame_count;
         frame_count = n + 16'd1;
         if (((int'(n) + NTAPS / 2) % 2) == 0) begin
            acc_lo = 0;
            acc_hi = 0;
            for (int k = 0; k < NTAPS; k++) begin
               prod = longint'(tap_bank[k]) * longint'(sample_line[k]);
               acc_lo += prod;
               acc_hi += (k % 2 == 1) ? prod : -prod;
            end
            band_pair.low_band  = round_q15(acc_lo, clip_lo);
            band_pair.high_band = round_q15(acc_hi, clip_hi);
            band_pair.saturated = clip_lo | clip_hi;
            pending_bands.push_back(band_pair);
         end
      end
   endtask

   task automatic send_word(input qmf_req_type w);
      while ($urandom_range(99) < send_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_filter(w);
   endtask

   task automatic load_tap(input int idx, input logic signed [15:0] val, input logic fs);
      qmf_req_type w;
      w.operation   = OP_LOAD;
      w.coef_index  = idx[4:0];
      w.value       = val;
      w.frame_start = fs;
      send_word(w);
   endtask

   task automatic push_sample(input logic signed [15:0] val, input logic fs);
      qmf_req_type w;
      w.operation   = OP_SAMPLE;
      w.coef_index  = 5'($urandom());
      w.value       = val;
      w.frame_start = fs;
      send_word(w);
   endtask

   function automatic logic signed [15:0] pick_value();
      logic signed [15:0] v;
      v = 16'($urandom());
      case ($urandom_range(7))
         0: v = 16'sh7FFF;
         1: v = 16'sh8000;
         2, 3: v = v >>> 5;
         4: v = v >>> 10;
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      qmf_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bands.size() == 0) begin
            $error("unexpected result word low_band=%0d high_band=%0d",
                   rsp_data.low_band, rsp_data.high_band);
            error_count++;
         end else begin
            want = pending_bands.pop_front();
            if (rsp_data.low_band !== want.low_band) begin
               $error("low_band expected %0d actual %0d", want.low_band, rsp_data.low_band);
               error_count++;
            end
            if (rsp_data.high_band !== want.high_band) begin
               $error("high_band expected %0d actual %0d", want.high_band, rsp_data.high_band);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %0b actual %0b", want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // outputs with all taps still at their reset value
   task automatic test_zero_taps();
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh1234, 1'b0);
   endtask

   // extreme taps at both ends, frame flag on a load word, clipping on both bands
   task automatic test_tap_extremes();
      load_tap(0, 16'sh8000, 1'b1);
      load_tap(1, 16'sh7FFF, 1'b0);
      load_tap(NTAPS - 1, 16'sh7FFF, 1'b0);
      push_sample(16'sh8000, 1'b1);
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh0000, 1'b0);
   endtask

   // frame restart on an off-phase position and back to back, tap change mid frame
   task automatic test_frame_restart();
      push_sample(16'sh4000, 1'b1);
      push_sample(16'shC000, 1'b0);
      push_sample(16'sh0001, 1'b1);
      push_sample(16'sh7FFF, 1'b1);
      load_tap(2, 16'sh2000, 1'b0);
      push_sample(16'shFFFF, 1'b0);
      push_sample(16'sh5555, 1'b0);
   endtask

   task automatic test_random_traffic(input int count);
      int r;
      int i;
      i = 0;
      while (i < count) begin
         r = $urandom_range(99);
         if (r < 1) begin
            for (int k = 0; k < NTAPS; k++) load_tap(k, pick_value(), 1'($urandom()));
            i += NTAPS;
         end else begin
            if (r < 10) load_tap($urandom_range(31), pick_value(), 1'($urandom()));
            else push_sample(pick_value(), (r < 13));
            i++;
         end
      end
   endtask

   initial begin
      foreach (tap_bank[k]) tap_bank[k] = '0;
      foreach (sample_line[k]) sample_line[k] = '0;
      frame_count = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct  = 28;
      rsp_stall_pct = 73;
      test_zero_taps();
      test_tap_extremes();
      test_frame_restart();
      test_random_traffic(650);

      send_gap_pct  = 73;
      rsp_stall_pct = 28;
      test_random_traffic(650);

      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random_traffic(600);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bands.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
